// ===== sv/bac_pkg.sv =====
// Package for the binned acceptance calibrator: sizes, codes and shared types.
// Used by every module and interface of the block; depends on nothing.

package bac_pkg;

   // Storage geometry.
   localparam int MAX_BUCKETS   = 64;
   localparam int BUCKET_BITS   = $clog2(MAX_BUCKETS);
   localparam int COUNT_BITS    = 32;

   // Item field widths.
   localparam int PROB_BITS     = 17;
   localparam int STATUS_BITS   = 2;
   localparam int NBUCKET_BITS  = 7;
   localparam int PRIOR_BITS    = 16;

   // Divider widths: a count in Q32.8 plus a prior sum needs COUNT_BITS + 9 bits.
   localparam int DIV_BITS      = COUNT_BITS + 9;
   localparam int QUOT_STEPS    = 16;
   localparam int STEP_BITS     = $clog2(QUOT_STEPS + 1);

   // Probability of one in Q1.16.
   localparam logic [PROB_BITS-1:0] PROB_ONE = PROB_BITS'(65536);

   // Configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes.
   localparam logic [1:0] REG_BUCKET_COUNT = 2'd0;
   localparam logic [1:0] REG_PRIOR_ACCEPT = 2'd1;
   localparam logic [1:0] REG_PRIOR_REJECT = 2'd2;

   // Register reset values.
   localparam logic [NBUCKET_BITS-1:0] BUCKET_COUNT_RESET = NBUCKET_BITS'(64);
   localparam logic [PRIOR_BITS-1:0]   PRIOR_RESET        = PRIOR_BITS'(256);

   // Operation codes.
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_PROB = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   // Configuration register values seen by the datapath.
   typedef struct packed {
      logic [NBUCKET_BITS-1:0] bucket_count;
      logic [PRIOR_BITS-1:0]   prior_accept;
      logic [PRIOR_BITS-1:0]   prior_reject;
   } cfg_type;

   // One bucket of the count store.
   typedef struct packed {
      logic [COUNT_BITS-1:0] accept_count;
      logic [COUNT_BITS-1:0] total_count;
   } entry_type;

   // Access request to the count store.
   typedef struct packed {
      logic                   rd_en;
      logic                   wr_en;
      logic [BUCKET_BITS-1:0] addr;
      entry_type              wr_entry;
   } store_req_type;

endpackage

// ===== sv/bac_req_if.sv =====
// Request channel of the calibrator: valid/ready handshake and input item fields.
// Depends on bac_pkg for the field widths.

interface bac_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [bac_pkg::PROB_BITS-1:0]    probability;
   logic                             accepted_flag;

   modport source (output valid, operation, probability, accepted_flag, input ready);
   modport sink   (input valid, operation, probability, accepted_flag, output ready);
endinterface

// ===== sv/bac_rsp_if.sv =====
// Response channel of the calibrator: valid/ready handshake and result item fields.
// Depends on bac_pkg for the field widths.

interface bac_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bac_pkg::STATUS_BITS-1:0]  status;
   logic [bac_pkg::PROB_BITS-1:0]    estimate;
   logic                             calibrated;

   modport source (output valid, status, estimate, calibrated, input ready);
   modport sink   (input valid, status, estimate, calibrated, output ready);
endinterface

// ===== sv/bac_csr.sv =====
// Configuration registers of the calibrator behind an APB-style port.
// Depends on bac_pkg for register indexes, reset values and cfg_type.

module bac_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bac_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bac_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bac_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output bac_pkg::cfg_type                   cfg
);

   bac_pkg::cfg_type cfg_ff;
   bac_pkg::cfg_type cfg_in;
   logic             wr_strobe;
   logic [1:0]       reg_index;

   // Registers sit on word addresses; the low address bits are ignored.
   assign reg_index  = csr_paddr[3:2];
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_index)
            bac_pkg::REG_BUCKET_COUNT:
               cfg_in.bucket_count = csr_pwdata[bac_pkg::NBUCKET_BITS-1:0];
            bac_pkg::REG_PRIOR_ACCEPT:
               cfg_in.prior_accept = csr_pwdata[bac_pkg::PRIOR_BITS-1:0];
            bac_pkg::REG_PRIOR_REJECT:
               cfg_in.prior_reject = csr_pwdata[bac_pkg::PRIOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read decode; an unused address reads as zero.
   always_comb begin
      case (reg_index)
         bac_pkg::REG_BUCKET_COUNT:
            csr_prdata = bac_pkg::CSR_DATA_BITS'(cfg_ff.bucket_count);
         bac_pkg::REG_PRIOR_ACCEPT:
            csr_prdata = bac_pkg::CSR_DATA_BITS'(cfg_ff.prior_accept);
         bac_pkg::REG_PRIOR_REJECT:
            csr_prdata = bac_pkg::CSR_DATA_BITS'(cfg_ff.prior_reject);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_count <= bac_pkg::BUCKET_COUNT_RESET;
         cfg_ff.prior_accept <= bac_pkg::PRIOR_RESET;
         cfg_ff.prior_reject <= bac_pkg::PRIOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/bac_store.sv =====
// Count store of the calibrator: one synchronous memory of bucket entries with
// a registered read and per-entry valid bits. Depends on bac_pkg.

module bac_store (
   input  logic                   clock,
   input  logic                   reset,
   input  bac_pkg::store_req_type req,
   output bac_pkg::entry_type     rd_entry
);

   bac_pkg::entry_type               mem [bac_pkg::MAX_BUCKETS];
   logic [bac_pkg::MAX_BUCKETS-1:0]  valid_ff;
   bac_pkg::entry_type               rd_entry_ff;
   logic                             rd_hit_ff;

   // An entry never written since reset reads as zero counts.
   assign rd_entry = rd_hit_ff ? rd_entry_ff : '0;

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_entry;
      end
      if (req.rd_en) begin
         rd_entry_ff <= mem[req.addr];
      end
   end

   // Valid bits clear at reset and mark written entries.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_hit_ff <= valid_ff[req.addr];
         end
      end
   end

endmodule

// ===== sv/bac_div.sv =====
// Radix-2 restoring divider giving a Q1.16 ratio num/den saturated at 1.0.
// Depends on bac_pkg for the operand and step widths.

module bac_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bac_pkg::DIV_BITS-1:0]     num,
   input  logic [bac_pkg::DIV_BITS-1:0]     den,
   output logic                             done,
   output logic [bac_pkg::PROB_BITS-1:0]    quotient
);

   logic [bac_pkg::DIV_BITS-1:0]   rem_ff,  rem_in;
   logic [bac_pkg::DIV_BITS-1:0]   den_ff,  den_in;
   logic [bac_pkg::PROB_BITS-1:0]  quot_ff, quot_in;
   logic [bac_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           first_ff, first_in;
   logic                           done_ff, done_in;
   logic [bac_pkg::DIV_BITS:0]     rem_dbl;
   logic                           fits;

   assign done     = done_ff;
   assign quotient = quot_ff;

   // Shifted remainder and the trial compare of one quotient bit.
   assign rem_dbl = {rem_ff, 1'b0};
   assign fits    = rem_dbl >= {1'b0, den_ff};

   // First cycle checks for a ratio of one or more, then one bit per cycle.
   always_comb begin
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = num;
         den_in   = den;
         quot_in  = '0;
         step_in  = bac_pkg::STEP_BITS'(bac_pkg::QUOT_STEPS);
         busy_in  = 1'b1;
         first_in = 1'b1;
      end else if (busy_ff && first_ff) begin
         first_in = 1'b0;
         if (rem_ff >= den_ff) begin
            quot_in = bac_pkg::PROB_ONE;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? bac_pkg::DIV_BITS'(rem_dbl - {1'b0, den_ff})
                        : rem_dbl[bac_pkg::DIV_BITS-1:0];
         quot_in = {quot_ff[bac_pkg::PROB_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == bac_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         first_ff <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         first_ff <= first_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

endmodule

// ===== sv/binned_acceptance_calibrator.sv =====
// Channel  | Direction | Handshake       | Item fields
// req_ch   | in        | valid/ready     | operation, probability, accepted_flag
// rsp_ch   | out       | valid/ready     | status, estimate, calibrated
// csr_*    | in        | APB write/read  | bucket_count, prior_accept, prior_reject
//
// One item is in work at a time. After an item is accepted, a bad probability passes
// through the bucket and done states, an update or a lookup of an empty bucket through
// the bucket, read and done states, and any other lookup through the bucket, read, divide
// and done states, with a saturation check and, unless it saturates, 16 quotient bits.
// Reset is synchronous and clears the bucket valid bits at once, so no clearing
// pass is needed. A result waits in the output register while the next item is
// accepted; a stalled output holds the finished item in its last state.
//
// Top level of the binned acceptance calibrator; uses bac_pkg, bac_req_if,
// bac_rsp_if, bac_csr, bac_store and bac_div.

module binned_acceptance_calibrator (
   input  logic                               clock,
   input  logic                               reset,
   bac_req_if.sink                            req_ch,
   bac_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bac_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bac_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bac_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUCKET,
      ST_READ,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic                               op_ff, op_in;
   logic [bac_pkg::PROB_BITS-1:0]      prob_ff, prob_in;
   logic                               acc_ff, acc_in;
   logic [bac_pkg::BUCKET_BITS-1:0]    bucket_ff, bucket_in;
   logic [bac_pkg::STATUS_BITS-1:0]    pend_status_ff, pend_status_in;
   logic [bac_pkg::PROB_BITS-1:0]      pend_estimate_ff, pend_estimate_in;
   logic                               pend_calibrated_ff, pend_calibrated_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bac_pkg::STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [bac_pkg::PROB_BITS-1:0]      rsp_estimate_ff, rsp_estimate_in;
   logic                               rsp_calibrated_ff, rsp_calibrated_in;

   bac_pkg::cfg_type                   cfg;
   bac_pkg::store_req_type             store_req;
   bac_pkg::entry_type                 rd_entry;
   logic                               div_start;
   logic                               div_done;
   logic [bac_pkg::DIV_BITS-1:0]       div_num;
   logic [bac_pkg::DIV_BITS-1:0]       div_den;
   logic [bac_pkg::PROB_BITS-1:0]      div_quot;

   logic [bac_pkg::NBUCKET_BITS-1:0]   n_use;
   logic [bac_pkg::NBUCKET_BITS-1:0]   n_last;
   logic [23:0]                        scaled;
   logic [7:0]                         raw_bucket;
   logic [bac_pkg::BUCKET_BITS-1:0]    bucket_sel;
   logic                               bad_prob;
   logic                               total_full;
   logic                               accept_full;
   logic                               out_free;

   bac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bac_store u_store (
      .clock    (clock),
      .reset    (reset),
      .req      (store_req),
      .rd_entry (rd_entry)
   );

   bac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Channel ports.
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.estimate   = rsp_estimate_ff;
   assign rsp_ch.calibrated = rsp_calibrated_ff;
   assign out_free          = !rsp_valid_ff || rsp_ch.ready;

   // Buckets in use, clamped to 1..MAX_BUCKETS.
   always_comb begin
      if (cfg.bucket_count == '0) begin
         n_use = bac_pkg::NBUCKET_BITS'(1);
      end else if (cfg.bucket_count > bac_pkg::NBUCKET_BITS'(bac_pkg::MAX_BUCKETS)) begin
         n_use = bac_pkg::NBUCKET_BITS'(bac_pkg::MAX_BUCKETS);
      end else begin
         n_use = cfg.bucket_count;
      end
   end

   // Bucket select: (p * n) >> 16, with a probability of one landing in the last bucket.
   assign n_last     = n_use - bac_pkg::NBUCKET_BITS'(1);
   assign scaled     = 24'(prob_ff) * 24'(n_use);
   assign raw_bucket = scaled[23:16];
   assign bucket_sel = (raw_bucket > 8'(n_last)) ? n_last[bac_pkg::BUCKET_BITS-1:0]
                                                 : raw_bucket[bac_pkg::BUCKET_BITS-1:0];
   assign bad_prob   = prob_ff > bac_pkg::PROB_ONE;

   // Saturation checks on the entry that was read.
   assign total_full  = &rd_entry.total_count;
   assign accept_full = &rd_entry.accept_count;

   // Smoothed ratio operands in Q33.8.
   assign div_num = {1'b0, rd_entry.accept_count, 8'h00}
                  + bac_pkg::DIV_BITS'(cfg.prior_accept);
   assign div_den = {1'b0, rd_entry.total_count, 8'h00}
                  + bac_pkg::DIV_BITS'(cfg.prior_accept)
                  + bac_pkg::DIV_BITS'(cfg.prior_reject);

   // Store access: read in the bucket cycle, write back in the read cycle.
   always_comb begin
      store_req                       = '0;
      store_req.addr                  = bucket_ff;
      store_req.wr_entry.total_count  = rd_entry.total_count + bac_pkg::COUNT_BITS'(1);
      store_req.wr_entry.accept_count = rd_entry.accept_count
                                      + bac_pkg::COUNT_BITS'(acc_ff);
      if (state_ff == ST_BUCKET) begin
         store_req.addr  = bucket_sel;
         store_req.rd_en = !bad_prob;
      end
      if (state_ff == ST_READ && op_ff == bac_pkg::OP_UPDATE) begin
         store_req.wr_en = !total_full && !(acc_ff && accept_full);
      end
   end

   assign div_start = (state_ff == ST_READ) && (op_ff == bac_pkg::OP_LOOKUP)
                   && (rd_entry.total_count != '0);

   // Item sequencer.
   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      prob_in            = prob_ff;
      acc_in             = acc_ff;
      bucket_in          = bucket_ff;
      pend_status_in     = pend_status_ff;
      pend_estimate_in   = pend_estimate_ff;
      pend_calibrated_in = pend_calibrated_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in      = rsp_status_ff;
      rsp_estimate_in    = rsp_estimate_ff;
      rsp_calibrated_in  = rsp_calibrated_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               prob_in  = req_ch.probability;
               acc_in   = req_ch.accepted_flag;
               state_in = ST_BUCKET;
            end
         end
         ST_BUCKET: begin
            bucket_in          = bucket_sel;
            pend_status_in     = bac_pkg::STATUS_OK;
            pend_estimate_in   = '0;
            pend_calibrated_in = 1'b0;
            if (bad_prob) begin
               pend_status_in = bac_pkg::STATUS_BAD_PROB;
               state_in       = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (op_ff == bac_pkg::OP_UPDATE) begin
               if (total_full || (acc_ff && accept_full)) begin
                  pend_status_in = bac_pkg::STATUS_OVERFLOW;
               end
               state_in = ST_DONE;
            end else if (rd_entry.total_count == '0) begin
               pend_estimate_in = prob_ff;
               state_in         = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pend_estimate_in   = div_quot;
               pend_calibrated_in = 1'b1;
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = pend_status_ff;
               rsp_estimate_in   = pend_estimate_ff;
               rsp_calibrated_in = pend_calibrated_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff              <= op_in;
      prob_ff            <= prob_in;
      acc_ff             <= acc_in;
      bucket_ff          <= bucket_in;
      pend_status_ff     <= pend_status_in;
      pend_estimate_ff   <= pend_estimate_in;
      pend_calibrated_ff <= pend_calibrated_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_estimate_ff    <= rsp_estimate_in;
      rsp_calibrated_ff  <= rsp_calibrated_in;
   end

   // The count store is written back only in the cycle after its read.
   assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> (state_ff == ST_READ) && $past(store_req.rd_en))
      else $error("count store written without a preceding read");

   // The divider reports only while a lookup waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // An accepted item moves straight into bucket selection.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_BUCKET))
      else $error("accepted item did not start bucket selection");

   // A calibrated result always carries an ok status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_calibrated_ff) |-> (rsp_status_ff == bac_pkg::STATUS_OK))
      else $error("calibrated result with an error status");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the binned acceptance calibrator: directed and random
// update/lookup items checked against a bucket-count predictor held in the bench.
// Depends on bac_pkg, bac_req_if, bac_rsp_if and binned_acceptance_calibrator.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 25;
   localparam int DRAIN_GUARD   = 20000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 380;
   localparam int TAIL_ITEMS    = 150;

   // One expected result item.
   typedef struct packed {
      logic [bac_pkg::STATUS_BITS-1:0] status;
      logic [bac_pkg::PROB_BITS-1:0]   estimate;
      logic                            calibrated;
   } calib_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [bac_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [bac_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [bac_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   bac_req_if req_ch ();
   bac_rsp_if rsp_ch ();

   binned_acceptance_calibrator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bench copy of the count store and of the registers.
   logic [bac_pkg::COUNT_BITS-1:0]   accept_tally [bac_pkg::MAX_BUCKETS];
   logic [bac_pkg::COUNT_BITS-1:0]   total_tally  [bac_pkg::MAX_BUCKETS];
   logic [bac_pkg::NBUCKET_BITS-1:0] cur_bucket_count;
   logic [bac_pkg::PRIOR_BITS-1:0]   cur_prior_accept;
   logic [bac_pkg::PRIOR_BITS-1:0]   cur_prior_reject;

   calib_result_type pending_results [$];
   int               mismatch_count = 0;
   bit               sender_idle = 1'b1;
   bit               sink_idle   = 1'b1;

   always #2 clock = ~clock;

   // Computes the result of one item and applies its effect on the counts.
   function automatic calib_result_type predict_calibration(
         input logic op,
         input logic [bac_pkg::PROB_BITS-1:0] prob,
         input logic acc);
      calib_result_type r;
      int unsigned      n;
      int unsigned      b;
      logic [63:0]      num;
      logic [63:0]      den;
      r.status     = bac_pkg::STATUS_OK;
      r.estimate   = '0;
      r.calibrated = 1'b0;
      if (prob > bac_pkg::PROB_ONE) begin
         r.status = bac_pkg::STATUS_BAD_PROB;
         return r;
      end
      n = cur_bucket_count;
      if (n == 0) n = 1;
      if (n > bac_pkg::MAX_BUCKETS) n = bac_pkg::MAX_BUCKETS;
      if (prob == bac_pkg::PROB_ONE) b = n - 1;
      else b = (int'(prob) * n) >> 16;
      if (b > n - 1) b = n - 1;
      if (op == bac_pkg::OP_UPDATE) begin
         // A saturated counter refuses the update and leaves the bucket alone.
         if (total_tally[b] == '1 || (acc && accept_tally[b] == '1)) begin
            r.status = bac_pkg::STATUS_OVERFLOW;
            return r;
         end
         total_tally[b]++;
         if (acc) accept_tally[b]++;
         return r;
      end
      // An empty bucket passes the probability through uncalibrated.
      if (total_tally[b] == 0) begin
         r.estimate = prob;
         return r;
      end
      num = (64'(accept_tally[b]) << 8) + 64'(cur_prior_accept);
      den = (64'(total_tally[b]) << 8) + 64'(cur_prior_accept) + 64'(cur_prior_reject);
      if (num >= den) r.estimate = bac_pkg::PROB_ONE;
      else r.estimate = bac_pkg::PROB_BITS'((num << 16) / den);
      r.calibrated = 1'b1;
      return r;
   endfunction

   function automatic void report_mismatch(input string what, input calib_result_type want,
                                           input calib_result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display({"%0t: %s: expected status %0d estimate %0d calibrated %0d, ",
                   "got status %0d estimate %0d calibrated %0d"},
                  $realtime, what, want.status, want.estimate, want.calibrated,
                  got.status, got.estimate, got.calibrated);
   endfunction

   // Result checker: every accepted result item is matched with the oldest prediction.
   always @(posedge clock) begin : result_check
      calib_result_type got;
      calib_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.status     = rsp_ch.status;
         got.estimate   = rsp_ch.estimate;
         got.calibrated = rsp_ch.calibrated;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.estimate !== want.estimate ||
                got.calibrated !== want.calibrated)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   // Result ready with random stall bursts.
   always @(posedge clock) begin : result_stall
      int stall_left;
      if (stall_left > 0) begin
         stall_left--;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offers one item, waits for its acceptance, then maybe leaves a gap.
   task automatic send_item(input logic op, input logic [bac_pkg::PROB_BITS-1:0] prob,
                            input logic acc);
      req_ch.valid         <= 1'b1;
      req_ch.operation     <= op;
      req_ch.probability   <= prob;
      req_ch.accepted_flag <= acc;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(predict_calibration(op, prob, acc));
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Stops offering items and waits until every expected result has come.
   task automatic drain_results();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_register(input logic [1:0] index,
                                 input logic [bac_pkg::CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         bac_pkg::REG_BUCKET_COUNT:
            cur_bucket_count = value[bac_pkg::NBUCKET_BITS-1:0];
         bac_pkg::REG_PRIOR_ACCEPT:
            cur_prior_accept = value[bac_pkg::PRIOR_BITS-1:0];
         bac_pkg::REG_PRIOR_REJECT:
            cur_prior_reject = value[bac_pkg::PRIOR_BITS-1:0];
         default: ;
      endcase
   endtask

   // Rewrites all three registers once the block has gone idle.
   task automatic configure(input int buckets, input int alpha, input int beta);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(bac_pkg::REG_BUCKET_COUNT, bac_pkg::CSR_DATA_BITS'(buckets));
      write_register(bac_pkg::REG_PRIOR_ACCEPT, bac_pkg::CSR_DATA_BITS'(alpha));
      write_register(bac_pkg::REG_PRIOR_REJECT, bac_pkg::CSR_DATA_BITS'(beta));
   endtask

   function automatic logic [bac_pkg::PROB_BITS-1:0] random_probability();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return bac_pkg::PROB_ONE;
         2: return bac_pkg::PROB_BITS'($urandom_range(65537, 131071));
         3: return bac_pkg::PROB_BITS'(65535);
         default: return bac_pkg::PROB_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic int random_prior();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return 65535;
         3: return $urandom_range(1, 1024);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int random_bucket_count();
      case ($urandom_range(0, 7))
         0: return 1;
         1: return 64;
         2: return 0;
         3: return $urandom_range(65, 127);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   // Empty buckets and bad probabilities under the reset register values.
   task automatic test_passthrough_and_bad_probability();
      send_item(bac_pkg::OP_LOOKUP, '0, 1'b0);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_ONE, 1'b1);
      send_item(bac_pkg::OP_UPDATE, bac_pkg::PROB_BITS'(65537), 1'b1);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(131071), 1'b0);
   endtask

   // Updates and counted lookups at both ends of the probability range.
   task automatic test_update_and_lookup();
      send_item(bac_pkg::OP_UPDATE, '0, 1'b1);
      send_item(bac_pkg::OP_UPDATE, '0, 1'b0);
      send_item(bac_pkg::OP_LOOKUP, '0, 1'b0);
      send_item(bac_pkg::OP_UPDATE, bac_pkg::PROB_ONE, 1'b1);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(65535), 1'b0);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(1023), 1'b1);
   endtask

   // Register extremes: one bucket, zero and out-of-range bucket counts, zero and full priors.
   task automatic test_register_extremes();
      configure(1, 1, 1);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(40000), 1'b0);
      configure(0, 0, 0);
      send_item(bac_pkg::OP_UPDATE, bac_pkg::PROB_BITS'(12345), 1'b1);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(12345), 1'b0);
      configure(127, 65535, 65535);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(32768), 1'b0);
      send_item(bac_pkg::OP_UPDATE, bac_pkg::PROB_BITS'(32768), 1'b0);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(32768), 1'b0);
      // With no priors an all-accepted bucket saturates and an all-rejected one reads zero.
      configure(127, 0, 0);
      send_item(bac_pkg::OP_UPDATE, bac_pkg::PROB_BITS'(50000), 1'b1);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(50000), 1'b0);
      send_item(bac_pkg::OP_LOOKUP, bac_pkg::PROB_BITS'(32768), 1'b1);
   endtask

   // Random items over several register settings, with one full pause mid-phase.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         configure(random_bucket_count(), random_prior(), random_prior());
         sender_idle = ($urandom_range(0, 3) != 0);
         sink_idle   = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 2 && k == PHASE_ITEMS / 2) drain_results();
            send_item(logic'($urandom_range(0, 1)), random_probability(),
                      logic'($urandom_range(0, 1)));
         end
      end
   endtask

   // Back-to-back items with no idling on either side.
   task automatic test_tail_no_idle();
      configure(64, 256, 256);
      sender_idle = 1'b0;
      sink_idle   = 1'b0;
      for (int k = 0; k < TAIL_ITEMS; k++)
         send_item(logic'($urandom_range(0, 1)), random_probability(),
                   logic'($urandom_range(0, 1)));
   endtask

   initial begin
      for (int i = 0; i < bac_pkg::MAX_BUCKETS; i++) begin
         accept_tally[i] = '0;
         total_tally[i]  = '0;
      end
      cur_bucket_count = bac_pkg::BUCKET_COUNT_RESET;
      cur_prior_accept = bac_pkg::PRIOR_RESET;
      cur_prior_reject = bac_pkg::PRIOR_RESET;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.operation     <= bac_pkg::OP_UPDATE;
      req_ch.probability   <= '0;
      req_ch.accepted_flag <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_passthrough_and_bad_probability();
      test_update_and_lookup();
      test_register_extremes();
      test_random_traffic();
      test_tail_no_idle();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit far above the slowest correct run.
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule
